// ===== rtl/gamd_pkg.sv =====
// Shared types, codes and widths for the gamepad axis motor drive.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gamd_pkg;

    localparam int DUTY_MAX = 1023;
    localparam int DUTY_W   = $clog2(DUTY_MAX + 1);

    localparam int TYPE_W  = 16;
    localparam int CODE_W  = 16;
    localparam int VALUE_W = 17;
    localparam int DZ_W    = 15;
    localparam int CTR_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;

    localparam int NUM_W   = 17;
    localparam int SPAN_W  = 16;
    localparam int PROD_W  = NUM_W + DUTY_W;
    localparam int AXIS_TOP = 65535;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [CIDX_W-1:0] CFG_DEADBAND   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_CENTER     = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BOOST_DUTY = 2'd2;

    localparam logic [CODE_W-1:0] CODE_BOOST = 16'd305;
    localparam logic [CODE_W-1:0] CODE_LV    = 16'd1;
    localparam logic [CODE_W-1:0] CODE_LH    = 16'd0;
    localparam logic [CODE_W-1:0] CODE_RV    = 16'd5;
    localparam logic [CODE_W-1:0] CODE_RH    = 16'd2;

    localparam logic [1:0] KIND_SYNC  = 2'd0;
    localparam logic [1:0] KIND_BOOST = 2'd1;
    localparam logic [1:0] KIND_STICK = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;

    localparam logic [1:0] PAIR_LV = 2'd0;
    localparam logic [1:0] PAIR_LH = 2'd1;
    localparam logic [1:0] PAIR_RV = 2'd2;
    localparam logic [1:0] PAIR_RH = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic              boost_on;
        logic [1:0]        pair;
        logic              hi;
        logic              zero;
        logic [NUM_W-1:0]  num;
        logic [SPAN_W-1:0] span;
    } qent_t;

    typedef struct packed {
        logic              line_a;
        logic              line_b;
        logic [DUTY_W-1:0] duty;
    } drive_t;

endpackage

`default_nettype wire

// ===== rtl/gamepad_axis_motor_drive.sv =====
// Top level of the gamepad axis motor drive: configuration registers, front
// end, event queue and back end. Depends on gamd_pkg, gamd_front, gamd_queue, gamd_back.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_stall    event_type, event_code, event_value
//   out      out_valid / out_stall  motor1_*, motor2_*, changed
//   cfg      cfg_write              cfg_index, cfg_data
//
// A stick event with a nonzero level passes from its accepting edge through a pop, a
// product, ten restoring divider steps and the commit before its result can be taken;
// other events pass through the pop and the commit. The back end works on one event at a time.
// The queue holds two events, so the input keeps accepting while one is divided.
// Reset clears the queue, the stored levels and the boost flag at once.
// A stalled result stays in the output register while the back end works on.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_axis_motor_drive
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [gamd_pkg::TYPE_W-1:0]          event_type,
    input  wire logic [gamd_pkg::CODE_W-1:0]          event_code,
    input  wire logic signed [gamd_pkg::VALUE_W-1:0]  event_value,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      motor1_line_a,
    output logic                                      motor1_line_b,
    output logic [gamd_pkg::DUTY_W-1:0]               motor1_duty,
    output logic                                      motor2_line_a,
    output logic                                      motor2_line_b,
    output logic [gamd_pkg::DUTY_W-1:0]               motor2_duty,
    output logic                                      changed,
    input  wire logic                                 cfg_write,
    input  wire logic [gamd_pkg::CIDX_W-1:0]          cfg_index,
    input  wire logic [gamd_pkg::CFG_W-1:0]           cfg_data
);

    logic [gamd_pkg::DZ_W-1:0]   deadband_reg;
    logic [gamd_pkg::CTR_W-1:0]  center_value_reg;
    logic [gamd_pkg::DUTY_W-1:0] boost_duty_reg;
    logic                        q_full;
    logic                        q_empty;
    logic                        q_push;
    logic                        q_pop;
    gamd_pkg::qent_t             q_in;
    gamd_pkg::qent_t             q_out;
    gamd_pkg::drive_t            motor1;
    gamd_pkg::drive_t            motor2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg     <= gamd_pkg::DZ_W'(3500);
            center_value_reg <= gamd_pkg::CTR_W'(32768);
            boost_duty_reg   <= gamd_pkg::DUTY_W'(550);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                gamd_pkg::CFG_DEADBAND:
                begin
                    deadband_reg <= cfg_data[gamd_pkg::DZ_W-1:0];
                end
                gamd_pkg::CFG_CENTER:
                begin
                    center_value_reg <= cfg_data[gamd_pkg::CTR_W-1:0];
                end
                gamd_pkg::CFG_BOOST_DUTY:
                begin
                    boost_duty_reg <= cfg_data[gamd_pkg::DUTY_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    gamd_front u_front
    (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .event_type   (event_type),
        .event_code   (event_code),
        .event_value  (event_value),
        .deadband     (deadband_reg),
        .center_value (center_value_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    gamd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    gamd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .boost_duty (boost_duty_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .motor1     (motor1),
        .motor2     (motor2),
        .changed    (changed)
    );

    assign motor1_line_a = motor1.line_a;
    assign motor1_line_b = motor1.line_b;
    assign motor1_duty   = motor1.duty;
    assign motor2_line_a = motor2.line_a;
    assign motor2_line_b = motor2.line_b;
    assign motor2_duty   = motor2.duty;

endmodule

`default_nettype wire

// ===== rtl/gamd_front.sv =====
// Front end: accepts events and classifies them into queue entries.
// Depends on gamd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gamd_front
(
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [gamd_pkg::TYPE_W-1:0]   event_type,
    input  wire logic [gamd_pkg::CODE_W-1:0]   event_code,
    input  wire logic signed [gamd_pkg::VALUE_W-1:0] event_value,
    input  wire logic [gamd_pkg::DZ_W-1:0]     deadband,
    input  wire logic [gamd_pkg::CTR_W-1:0]    center_value,
    input  wire logic                          q_full,
    output logic                               q_push,
    output gamd_pkg::qent_t                    q_data
);

    logic signed [17:0] v;
    logic signed [17:0] c;
    logic signed [17:0] dz;
    logic signed [17:0] span_lo;
    logic signed [17:0] start_hi;
    logic signed [17:0] span_hi;
    logic signed [17:0] num_lo;
    logic signed [17:0] num_hi;
    logic               low_half;
    logic               zero_lo;
    logic               zero_hi;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    assign v        = 18'(event_value);
    assign c        = $signed({2'b00, center_value});
    assign dz       = $signed({3'b000, deadband});
    assign low_half = v < c;
    assign span_lo  = c - dz;
    assign num_lo   = span_lo - v;
    assign zero_lo  = (v > span_lo) || (span_lo <= 18'sd0);
    assign start_hi = c + dz;
    assign span_hi  = 18'(gamd_pkg::AXIS_TOP) - start_hi;
    assign num_hi   = v - start_hi;
    assign zero_hi  = (v < start_hi) || (span_hi <= 18'sd0);

    always_comb
    begin
        q_data          = '0;
        q_data.boost_on = event_value != '0;
        q_data.hi       = !low_half;
        if (low_half)
        begin
            q_data.zero = zero_lo;
            q_data.num  = num_lo[gamd_pkg::NUM_W-1:0];
            q_data.span = span_lo[gamd_pkg::SPAN_W-1:0];
        end
        else
        begin
            q_data.zero = zero_hi;
            q_data.num  = num_hi[gamd_pkg::NUM_W-1:0];
            q_data.span = span_hi[gamd_pkg::SPAN_W-1:0];
        end

        if (event_type == '0)
        begin
            q_data.kind = gamd_pkg::KIND_SYNC;
        end
        else
        begin
            priority case (event_code)
                gamd_pkg::CODE_BOOST:
                begin
                    q_data.kind = gamd_pkg::KIND_BOOST;
                end
                gamd_pkg::CODE_LV:
                begin
                    q_data.kind = gamd_pkg::KIND_STICK;
                    q_data.pair = gamd_pkg::PAIR_LV;
                end
                gamd_pkg::CODE_LH:
                begin
                    q_data.kind = gamd_pkg::KIND_STICK;
                    q_data.pair = gamd_pkg::PAIR_LH;
                end
                gamd_pkg::CODE_RV:
                begin
                    q_data.kind = gamd_pkg::KIND_STICK;
                    q_data.pair = gamd_pkg::PAIR_RV;
                end
                gamd_pkg::CODE_RH:
                begin
                    q_data.kind = gamd_pkg::KIND_STICK;
                    q_data.pair = gamd_pkg::PAIR_RH;
                end
                default:
                begin
                    q_data.kind = gamd_pkg::KIND_OTHER;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gamd_queue.sv =====
// Short FIFO of classified events between the front and back ends.
// Depends on gamd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gamd_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire gamd_pkg::qent_t push_data,
    input  wire logic            pop,
    output gamd_pkg::qent_t      pop_data,
    output logic                 full,
    output logic                 empty
);

    gamd_pkg::qent_t                  mem_reg [gamd_pkg::QDEPTH];
    logic [gamd_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [gamd_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [gamd_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [gamd_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [gamd_pkg::QCNT_W-1:0]      count_reg;
    logic [gamd_pkg::QCNT_W-1:0]      count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full     = count_reg == gamd_pkg::QCNT_W'(gamd_pkg::QDEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == gamd_pkg::QPTR_W'(gamd_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == gamd_pkg::QPTR_W'(gamd_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gamd_back.sv =====
// Back end: scales stick levels with an iterative divider, keeps controller
// state and registers the motor drive result. Depends on gamd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gamd_back
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_empty,
    input  wire gamd_pkg::qent_t              q_data,
    output logic                              q_pop,
    input  wire logic [gamd_pkg::DUTY_W-1:0]  boost_duty,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output gamd_pkg::drive_t                  motor1,
    output gamd_pkg::drive_t                  motor2,
    output logic                              changed
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam int DIV_W = gamd_pkg::SPAN_W + gamd_pkg::DUTY_W - 1;
    localparam int BIT_W = $clog2(gamd_pkg::DUTY_W);

    function automatic gamd_pkg::drive_t drive_of
    (
        input logic [gamd_pkg::DUTY_W-1:0] up,
        input logic [gamd_pkg::DUTY_W-1:0] down,
        input logic                        boost,
        input logic [gamd_pkg::DUTY_W-1:0] bduty
    );
        gamd_pkg::drive_t d;
        if (up != '0)
        begin
            d = '{line_a: 1'b1, line_b: 1'b0, duty: up};
        end
        else if (down != '0)
        begin
            d = '{line_a: 1'b0, line_b: 1'b1, duty: down};
        end
        else if (boost)
        begin
            d = '{line_a: 1'b1, line_b: 1'b0, duty: bduty};
        end
        else
        begin
            d = '{line_a: 1'b1, line_b: 1'b1, duty: '0};
        end
        return d;
    endfunction

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    gamd_pkg::qent_t                 ent_reg;
    logic [gamd_pkg::PROD_W-1:0]     rem_reg;
    logic [DIV_W-1:0]                div_reg;
    logic [gamd_pkg::DUTY_W-1:0]     quo_reg;
    logic [BIT_W-1:0]                bit_reg;
    logic                            sat_reg;
    logic [gamd_pkg::DUTY_W-1:0]     levels_reg [8];
    logic [gamd_pkg::DUTY_W-1:0]     levels_next [8];
    logic                            boost_reg;
    logic                            boost_next;
    logic                            out_valid_reg;
    gamd_pkg::drive_t                motor1_reg;
    gamd_pkg::drive_t                motor2_reg;
    logic                            changed_reg;
    logic                            changed_next;
    logic                            commit;
    logic [gamd_pkg::DUTY_W-1:0]     level;
    logic [2:0]                      keep_idx;
    logic [2:0]                      clear_idx;
    logic                            sat_lim;
    logic [gamd_pkg::PROD_W-1:0]     div_ext;

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign commit    = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign keep_idx  = {ent_reg.pair, ent_reg.hi};
    assign clear_idx = {ent_reg.pair, !ent_reg.hi};
    assign sat_lim   = rem_reg >=
                       gamd_pkg::PROD_W'(ent_reg.span) *
                       gamd_pkg::PROD_W'(gamd_pkg::DUTY_MAX + 1);
    assign div_ext   = gamd_pkg::PROD_W'(div_reg);

    assign out_valid = out_valid_reg;
    assign motor1    = motor1_reg;
    assign motor2    = motor2_reg;
    assign changed   = changed_reg;

    always_comb
    begin
        priority if (ent_reg.zero)
        begin
            level = '0;
        end
        else if (sat_reg)
        begin
            level = gamd_pkg::DUTY_W'(gamd_pkg::DUTY_MAX);
        end
        else
        begin
            level = quo_reg;
        end
    end

    always_comb
    begin
        levels_next  = levels_reg;
        boost_next   = boost_reg;
        changed_next = 1'b1;
        unique case (ent_reg.kind)
            gamd_pkg::KIND_SYNC:
            begin
                changed_next = 1'b0;
            end
            gamd_pkg::KIND_BOOST:
            begin
                boost_next = ent_reg.boost_on;
            end
            gamd_pkg::KIND_STICK:
            begin
                changed_next           = level != levels_reg[keep_idx];
                levels_next[clear_idx] = '0;
                levels_next[keep_idx]  = level;
            end
            default:
            begin
                changed_next = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    state_next = (q_data.kind == gamd_pkg::KIND_STICK && !q_data.zero) ?
                                 ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (bit_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            default:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            boost_reg     <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                levels_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                boost_reg     <= boost_next;
                levels_reg    <= levels_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ent_reg <= q_data;
            sat_reg <= 1'b0;
        end
        unique case (state_reg)
            ST_MUL:
            begin
                rem_reg <= gamd_pkg::PROD_W'(ent_reg.num) *
                           gamd_pkg::PROD_W'(gamd_pkg::DUTY_MAX);
                div_reg <= {ent_reg.span, (gamd_pkg::DUTY_W - 1)'(0)};
                quo_reg <= '0;
                bit_reg <= BIT_W'(gamd_pkg::DUTY_W - 1);
            end
            ST_DIV:
            begin
                if (bit_reg == BIT_W'(gamd_pkg::DUTY_W - 1))
                begin
                    sat_reg <= sat_lim;
                end
                if (rem_reg >= div_ext)
                begin
                    rem_reg <= rem_reg - div_ext;
                    quo_reg <= {quo_reg[gamd_pkg::DUTY_W-2:0], 1'b1};
                end
                else
                begin
                    quo_reg <= {quo_reg[gamd_pkg::DUTY_W-2:0], 1'b0};
                end
                div_reg <= div_reg >> 1;
                bit_reg <= bit_reg - 1'b1;
            end
            default:
            begin
            end
        endcase
        if (commit)
        begin
            motor1_reg  <= drive_of(levels_next[0], levels_next[1], boost_next, boost_duty);
            motor2_reg  <= drive_of(levels_next[4], levels_next[5], 1'b0, boost_duty);
            changed_reg <= changed_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gamd_checker.sv =====
// Port-level checks for the gamepad axis motor drive, bound to the top level.
// Depends on gamd_pkg and gamepad_axis_motor_drive.
`timescale 1ns / 1ps
`default_nettype none

module gamd_checker
(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_stall,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic                           motor1_line_a,
    input wire logic                           motor1_line_b,
    input wire logic [gamd_pkg::DUTY_W-1:0]    motor1_duty,
    input wire logic                           motor2_line_a,
    input wire logic                           motor2_line_b,
    input wire logic [gamd_pkg::DUTY_W-1:0]    motor2_duty,
    input wire logic                           changed
);

    logic [3:0] pend_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pend_reg <= pend_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(motor1_duty) &&
        $stable(motor2_duty) && $stable(changed))
        else $error("stalled result changed");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("result without a pending item");

    a_brake_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((motor1_line_a && motor1_line_b && motor1_duty != '0) ||
        (motor2_line_a && motor2_line_b && motor2_duty != '0)) |-> 1'b0)
        else $error("brake with nonzero duty");

    a_lines_live: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (motor1_line_a || motor1_line_b) && (motor2_line_a || motor2_line_b))
        else $error("bridge with both lines low");

    a_reverse_duty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((!motor1_line_a && motor1_duty == '0) ||
        (!motor2_line_a && motor2_duty == '0)) |-> 1'b0)
        else $error("reverse drive with zero duty");

endmodule

bind gamepad_axis_motor_drive gamd_checker u_gamd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .motor1_line_a (motor1_line_a),
    .motor1_line_b (motor1_line_b),
    .motor1_duty   (motor1_duty),
    .motor2_line_a (motor2_line_a),
    .motor2_line_b (motor2_line_b),
    .motor2_duty   (motor2_duty),
    .changed       (changed)
);

`default_nettype wire
